// ===== sv/srb_pkg.sv =====
// Package for the sequence reorder buffer: widths, codes and word types.
package srb_pkg;

  localparam int DEPTH  = 64;
  localparam int SEQ_W  = 32;
  localparam int DATA_W = 64;
  localparam int IDX_W  = $clog2(DEPTH);
  localparam int MODE_W = 2;
  localparam int STAT_W = 4;

  // operation codes
  localparam logic [MODE_W-1:0] MODE_ADD     = 2'd0;
  localparam logic [MODE_W-1:0] MODE_GET     = 2'd1;
  localparam logic [MODE_W-1:0] MODE_START   = 2'd2;
  localparam logic [MODE_W-1:0] MODE_ADVANCE = 2'd3;

  // status codes
  localparam logic [STAT_W-1:0] ST_OK          = 4'd0;
  localparam logic [STAT_W-1:0] ST_NOT_STARTED = 4'd1;
  localparam logic [STAT_W-1:0] ST_INVALID     = 4'd2;
  localparam logic [STAT_W-1:0] ST_FULL        = 4'd3;
  localparam logic [STAT_W-1:0] ST_EXISTS      = 4'd4;
  localparam logic [STAT_W-1:0] ST_BUSY        = 4'd5;
  localparam logic [STAT_W-1:0] ST_NOT_READY   = 4'd6;
  localparam logic [STAT_W-1:0] ST_STARTED     = 4'd7;
  localparam logic [STAT_W-1:0] ST_BACKWARD    = 4'd8;

  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic [SEQ_W-1:0]  seq;
    logic [DATA_W-1:0] data_in;
  } in_word_t;

  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic [SEQ_W-1:0]  seq_out;
    logic [DATA_W-1:0] data_out;
    logic              next_ready;
  } out_word_t;

  // controller -> datapath
  typedef struct packed {
    logic load_in;    // capture the accepted input word
    logic rd_item;    // read slot of the item (add) or of the head
    logic rd_head;    // read slot of the updated head
    logic exec;       // apply the operation
    logic load_out;   // move the finished result to the output register
  } srb_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic out_free;   // output register empty or being drained this cycle
  } srb_sts_t;

endpackage

// ===== sv/sequence_reorder_buffer.sv =====
// Top level of the sequence reorder buffer: controller plus datapath.
//
// channel  dir  handshake           word
// in_      in   in_valid/in_ready   in_data  {mode, seq, data_in}
// out_     out  out_valid/out_ready out_data {status, seq_out, data_out, next_ready}
//
// Each word occupies the block from its accept to the next accept: the
// accepting edge captures it, then one slot read, one execute (slot write, valid
// bits, head counter), one re-read of the new head slot for next_ready and the
// load of the output register; no new word is taken before that. A new word
// is taken while the last result waits on out_ready; the block then holds its
// result until the output register frees. Reset (synchronous, rst_n low)
// clears all valid bits, the head counter and the output valid; slot contents
// need no clearing.
module sequence_reorder_buffer (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  srb_pkg::in_word_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output srb_pkg::out_word_t out_data
);
  import srb_pkg::*;

  srb_cmd_t cmd;
  srb_sts_t sts;

  // sequencing of read / execute / re-read / output
  srb_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // slot memory, valid bits, head counter, result registers
  srb_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cmd       (cmd),
    .sts       (sts),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

// ===== sv/srb_ctrl.sv =====
// Controller state machine of the sequence reorder buffer.
module srb_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  srb_pkg::srb_sts_t sts,
  output srb_pkg::srb_cmd_t cmd
);
  import srb_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_RD1  = 3'd1;
  localparam logic [2:0] S_EXEC = 3'd2;
  localparam logic [2:0] S_RD2  = 3'd3;
  localparam logic [2:0] S_DONE = 3'd4;

  logic [2:0] state_r, state_nxt;

  assign in_ready = (state_r == S_IDLE);

  always_comb begin
    state_nxt    = state_r;
    cmd          = '0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load_in = 1'b1;
          state_nxt   = S_RD1;
        end
      end
      S_RD1: begin
        cmd.rd_item = 1'b1;
        state_nxt   = S_EXEC;
      end
      S_EXEC: begin
        cmd.exec  = 1'b1;
        state_nxt = S_RD2;
      end
      S_RD2: begin
        cmd.rd_head = 1'b1;
        state_nxt   = S_DONE;
      end
      S_DONE: begin
        // hold the result until the output register frees up
        if (sts.out_free) begin
          cmd.load_out = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// ===== sv/srb_dp.sv =====
// Datapath of the sequence reorder buffer: slot memory, valid bits, head counter.
module srb_dp (
  input  logic              clk,
  input  logic              rst_n,
  input  srb_pkg::in_word_t in_data,
  input  srb_pkg::srb_cmd_t cmd,
  output srb_pkg::srb_sts_t sts,
  output logic              out_valid,
  input  logic              out_ready,
  output srb_pkg::out_word_t out_data
);
  import srb_pkg::*;

  localparam int ENT_W = SEQ_W + DATA_W;

  // slot memory: {tag, payload}
  logic [ENT_W-1:0] mem [DEPTH];
  logic [ENT_W-1:0] rdata_r;
  logic             mem_we;
  logic [IDX_W-1:0] mem_ra;

  logic [DEPTH-1:0] valid_r, valid_nxt;
  logic [SEQ_W-1:0] next_seq_r, next_seq_nxt;
  in_word_t         in_r;

  logic [STAT_W-1:0] res_status_r, res_status_nxt;
  logic [SEQ_W-1:0]  res_seq_r, res_seq_nxt;
  logic [DATA_W-1:0] res_data_r, res_data_nxt;

  out_word_t out_r;
  logic      out_valid_r;

  logic [IDX_W-1:0] item_idx, head_idx;
  logic [SEQ_W-1:0] rd_tag;
  logic [DATA_W-1:0] rd_pay;
  logic [SEQ_W:0]   win_end;
  logic             head_hit, next_ready;

  assign item_idx = in_r.seq[IDX_W-1:0];
  assign head_idx = next_seq_r[IDX_W-1:0];
  assign rd_tag   = rdata_r[ENT_W-1:DATA_W];
  assign rd_pay   = rdata_r[DATA_W-1:0];
  assign win_end  = {1'b0, next_seq_r} + (SEQ_W+1)'(DEPTH);
  assign mem_ra   = cmd.rd_item && (in_r.mode == MODE_ADD) ? item_idx : head_idx;
  // for a get, exec follows a read of the head slot, so rdata holds its tag
  assign head_hit = valid_r[head_idx] && (rd_tag == next_seq_r);

  always_comb begin
    valid_nxt      = valid_r;
    next_seq_nxt   = next_seq_r;
    res_status_nxt = ST_OK;
    res_data_nxt   = '0;
    res_seq_nxt    = '0;
    mem_we         = 1'b0;
    case (in_r.mode)
      MODE_ADD: begin
        if (next_seq_r == '0) begin
          res_status_nxt = ST_NOT_STARTED;
        end else if (in_r.seq < next_seq_r) begin
          res_status_nxt = ST_INVALID;
        end else if ({1'b0, in_r.seq} >= win_end) begin
          res_status_nxt = ST_FULL;
        end else if (valid_r[item_idx] && (rd_tag >= in_r.seq)) begin
          res_status_nxt = ST_EXISTS;
        end else if (valid_r[item_idx]) begin
          res_status_nxt = ST_BUSY;
        end else begin
          mem_we              = cmd.exec;
          valid_nxt[item_idx] = 1'b1;
        end
      end
      MODE_GET: begin
        if (head_hit) begin
          res_data_nxt        = rd_pay;
          valid_nxt[head_idx] = 1'b0;
          next_seq_nxt        = next_seq_r + SEQ_W'(1);
        end else begin
          res_status_nxt = ST_NOT_READY;
        end
      end
      MODE_START: begin
        if (in_r.seq == '0) begin
          res_status_nxt = ST_INVALID;
        end else if (next_seq_r != '0) begin
          res_status_nxt = ST_STARTED;
        end else begin
          next_seq_nxt = in_r.seq;
        end
      end
      MODE_ADVANCE: begin
        if (in_r.seq < next_seq_r) begin
          res_status_nxt = ST_BACKWARD;
        end else begin
          next_seq_nxt = in_r.seq;
        end
      end
      default: res_status_nxt = ST_OK;
    endcase
    // popped item reports its own number, otherwise the updated head
    if ((in_r.mode == MODE_GET) && head_hit) begin
      res_seq_nxt = next_seq_r;
    end else begin
      res_seq_nxt = next_seq_nxt;
    end
  end

  // after the head re-read, rdata holds the slot of the updated head
  assign next_ready = valid_r[head_idx] && (rd_tag == next_seq_r);

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[item_idx] <= {in_r.seq, in_r.data_in};
    end
    if (cmd.rd_item || cmd.rd_head) begin
      rdata_r <= mem[mem_ra];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      in_r <= in_data;
    end
    if (cmd.exec) begin
      res_status_r <= res_status_nxt;
      res_seq_r    <= res_seq_nxt;
      res_data_r   <= res_data_nxt;
    end
    if (cmd.load_out) begin
      out_r.status     <= res_status_r;
      out_r.seq_out    <= res_seq_r;
      out_r.data_out   <= res_data_r;
      out_r.next_ready <= next_ready;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r     <= '0;
      next_seq_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.exec) begin
        valid_r    <= valid_nxt;
        next_seq_r <= next_seq_nxt;
      end
      if (cmd.load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign sts.out_free = !out_valid_r || out_ready;
  assign out_valid    = out_valid_r;
  assign out_data     = out_r;

endmodule

// ===== bench/tb_top.sv =====
// Testbench for sequence_reorder_buffer: directed, hold-off and random session tests.
`timescale 1ns / 1ps

module tb_top;
  import srb_pkg::*;

  localparam int ITEM_TARGET = 1850;

  // Clock, reset and the two channels. Every driven signal starts at a known value.
  logic      clk       = 1'b0;
  logic      rst_n     = 1'b0;
  logic      in_valid  = 1'b0;
  logic      in_ready;
  in_word_t  in_data   = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_word_t out_data;

  sequence_reorder_buffer i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Shadow copy of the buffer: head counter plus the slot ring.
  logic [SEQ_W-1:0]  head_seq = '0;
  logic              slot_full    [DEPTH];
  logic [SEQ_W-1:0]  slot_tag     [DEPTH];
  logic [DATA_W-1:0] slot_payload [DEPTH];

  // Results still owed by the block, oldest first.
  out_word_t expected_results[$];
  out_word_t want;

  int words_sent      = 0;
  int results_checked = 0;
  int mismatches      = 0;
  int seq_wraps       = 0;
  int status_hits [0:8] = '{default: 0};

  // Sender burst state and receiver stall state.
  int burst_left     = 0;
  int sender_gapless = 0;
  int hold_request   = 0;
  int hold_left      = 0;
  int pattern_pos    = 0;
  logic [15:0] ready_pattern = 16'hFFFF;

  initial begin
    for (int i = 0; i < DEPTH; i++) begin
      slot_full[i]    = 1'b0;
      slot_tag[i]     = '0;
      slot_payload[i] = '0;
    end
  end

  // True when the slot of the head counter holds the head sequence.
  function automatic logic head_present();
    int unsigned idx;
    idx = head_seq % DEPTH;
    return slot_full[idx] && (slot_tag[idx] == head_seq);
  endfunction

  // Applies one word to the shadow buffer and returns the result it owes.
  function automatic out_word_t reorder_step(in_word_t w);
    out_word_t   r;
    int unsigned idx;
    logic        popped;
    r        = '0;
    r.status = ST_OK;
    popped   = 1'b0;
    case (w.mode)
      MODE_ADD: begin
        idx = w.seq % DEPTH;
        if (head_seq == '0) begin
          r.status = ST_NOT_STARTED;
        end else if (w.seq < head_seq) begin
          r.status = ST_INVALID;
        end else if ({1'b0, w.seq} >= {1'b0, head_seq} + 33'(DEPTH)) begin
          // window test is 33 bits wide, so the window never wraps
          r.status = ST_FULL;
        end else if (slot_full[idx] && slot_tag[idx] >= w.seq) begin
          r.status = ST_EXISTS;
        end else if (slot_full[idx]) begin
          r.status = ST_BUSY;
        end else begin
          slot_full[idx]    = 1'b1;
          slot_tag[idx]     = w.seq;
          slot_payload[idx] = w.data_in;
        end
      end
      MODE_GET: begin
        if (head_present()) begin
          idx            = head_seq % DEPTH;
          r.seq_out      = head_seq;
          r.data_out     = slot_payload[idx];
          slot_full[idx] = 1'b0;
          if (head_seq == '1) seq_wraps++;
          head_seq       = head_seq + 1'b1;
          popped         = 1'b1;
        end else begin
          r.status = ST_NOT_READY;
        end
      end
      MODE_START: begin
        if (w.seq == '0) begin
          r.status = ST_INVALID;
        end else if (head_seq != '0) begin
          r.status = ST_STARTED;
        end else begin
          head_seq = w.seq;
        end
      end
      default: begin
        if (w.seq < head_seq) begin
          r.status = ST_BACKWARD;
        end else begin
          head_seq = w.seq;
        end
      end
    endcase
    if (!popped) r.seq_out = head_seq;
    r.next_ready = head_present();
    return r;
  endfunction

  function automatic logic [DATA_W-1:0] rand_payload();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return '1;
      default: return DATA_W'({$urandom, $urandom});
    endcase
  endfunction

  // Offers one word, in bursts with random gaps. Returns at the accepting
  // edge with the prediction already queued.
  task automatic send_word(input logic [MODE_W-1:0] mode, input logic [SEQ_W-1:0] seq,
                           input logic [DATA_W-1:0] payload);
    in_word_t w;
    int       gap;
    w.mode    = mode;
    w.seq     = seq;
    w.data_in = payload;
    if (burst_left == 0) begin
      if (sender_gapless == 0) begin
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
        if (gap > 0) begin
          in_valid <= 1'b0;
          repeat (gap) @(posedge clk);
        end
      end
      burst_left = $urandom_range(1, 24);
    end
    burst_left--;
    in_valid <= 1'b1;
    in_data  <= w;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    expected_results.push_back(reorder_step(w));
    words_sent++;
  endtask

  // Stops offering and waits until every owed result has come back.
  task automatic wait_drained();
    in_valid   <= 1'b0;
    burst_left = 0;
    do @(posedge clk); while (expected_results.size() != 0);
  endtask

  // Malformed, off-window or random words that leave no entry behind the head.
  task automatic send_noise();
    logic [SEQ_W-1:0] s;
    case ($urandom_range(0, 7))
      0: begin
        s = (head_seq == '0) ? $urandom : $urandom_range(0, head_seq - 1);
        send_word(MODE_ADD, s, rand_payload());
      end
      1: begin
        s = (head_seq <= 32'hFFFF_FFBF) ? $urandom_range(head_seq + 64, 32'hFFFF_FFFF)
                                         : $urandom;
        send_word(MODE_ADD, s, rand_payload());
      end
      2: send_word(MODE_ADD, $urandom, rand_payload());
      3: begin
        if (head_seq != '0) send_word(MODE_START, $urandom, rand_payload());
        else send_word(MODE_GET, $urandom, rand_payload());
      end
      4: send_word(MODE_START, '0, rand_payload());
      5: begin
        if (head_seq != '0) begin
          send_word(MODE_ADVANCE, $urandom_range(0, head_seq - 1), rand_payload());
        end else begin
          send_word(MODE_GET, $urandom, rand_payload());
        end
      end
      6: send_word(MODE_ADD, head_seq, rand_payload());
      default: send_word(MODE_GET, $urandom, rand_payload());
    endcase
  endtask

  // Adds count consecutive sequences from lo in shuffled order, with gets
  // and noise mixed in.
  task automatic add_shuffled(input logic [SEQ_W-1:0] lo, input int count);
    logic [SEQ_W-1:0] seqs [DEPTH];
    logic [SEQ_W-1:0] tmp;
    int               i;
    int               j;
    for (i = 0; i < count; i++) seqs[i] = lo + i;
    for (i = count - 1; i > 0; i--) begin
      j       = $urandom_range(0, i);
      tmp     = seqs[i];
      seqs[i] = seqs[j];
      seqs[j] = tmp;
    end
    for (i = 0; i < count; i++) begin
      if ($urandom_range(0, 5) == 0) send_word(MODE_GET, $urandom, rand_payload());
      if ($urandom_range(0, 7) == 0) send_noise();
      send_word(MODE_ADD, seqs[i], rand_payload());
    end
  endtask

  // Pops while the head is present, then one get that finds nothing.
  task automatic pop_ready();
    while (head_present()) send_word(MODE_GET, $urandom, rand_payload());
    send_word(MODE_GET, $urandom, rand_payload());
  endtask

  // Jumps to and pops every entry still at or above the head, lowest first,
  // so no entry gets stranded behind a later advance.
  task automatic flush_window();
    logic             found;
    logic [SEQ_W-1:0] low_tag;
    int               i;
    forever begin
      found   = 1'b0;
      low_tag = '0;
      for (i = 0; i < DEPTH; i++) begin
        if (slot_full[i] && (head_seq == '0 || slot_tag[i] >= head_seq) &&
            (!found || slot_tag[i] < low_tag)) begin
          found   = 1'b1;
          low_tag = slot_tag[i];
        end
      end
      if (!found) break;
      if (head_seq == '0) send_word(MODE_START, low_tag, rand_payload());
      else send_word(MODE_ADVANCE, low_tag, rand_payload());
      send_word(MODE_GET, $urandom, rand_payload());
    end
  endtask

  // One well-formed session: set the head, fill part of the window out of
  // order, drain it. Near the top of the sequence space the session runs
  // through the wrap instead.
  task automatic run_session();
    int               count;
    int unsigned      roll;
    logic [SEQ_W-1:0] lo;
    if ($urandom_range(0, 3) == 0) repeat ($urandom_range(1, 4)) send_noise();
    if (head_seq >= 32'hF000_0000) begin
      count = $urandom_range(1, 20);
      lo    = 32'hFFFF_FFFF - (count - 1);
      if (head_seq > lo) begin
        lo    = head_seq;
        count = int'(32'hFFFF_FFFF - lo) + 1;
      end
      send_word(MODE_ADVANCE, lo, rand_payload());
    end else begin
      roll = $urandom_range(0, 9);
      if (head_seq == '0) begin
        send_word(MODE_START, $urandom_range(1, 32'hEFFF_FFFF), rand_payload());
      end else if (roll == 0) begin
        // jump near the top so that a wrap session follows
        send_word(MODE_ADVANCE, $urandom_range(32'hF000_0000, 32'hFFFF_FFBF),
                  rand_payload());
      end else if (roll < 5) begin
        send_word(MODE_ADVANCE, head_seq + $urandom_range(0, 200), rand_payload());
      end else if (roll < 7) begin
        send_word(MODE_ADVANCE, head_seq + $urandom_range(0, 32'h00FF_FFFF), rand_payload());
      end
      roll  = $urandom_range(0, 19);
      count = (roll == 0) ? DEPTH : (roll < 5) ? $urandom_range(13, 40) : $urandom_range(1, 12);
      lo    = head_seq;
    end
    add_shuffled(lo, count);
    pop_ready();
    flush_window();
  endtask

  task automatic test_edge_cases();
    send_word(MODE_GET, '0, '0);                           // get before start
    send_word(MODE_ADD, 32'h5, 64'h1);                     // add before start
    send_word(MODE_ADVANCE, '0, '0);                       // advance to zero, still unstarted
    send_word(MODE_START, '0, '0);                         // start at zero is rejected
    send_word(MODE_START, 32'h100, '0);
    send_word(MODE_START, 32'h200, '1);                    // second start
    send_word(MODE_ADD, 32'hFF, '1);                       // below the head
    send_word(MODE_ADD, 32'h140, '1);                      // first seq past the window
    send_word(MODE_ADD, 32'h13F, '1);                      // last seq in the window
    send_word(MODE_ADD, 32'h100, '0);
    send_word(MODE_ADD, 32'h100, 64'h5A5A_A5A5_0F0F_F0F0); // duplicate
    send_word(MODE_GET, '1, '1);
    send_word(MODE_GET, '0, '0);                           // 0x101 missing
    send_word(MODE_ADVANCE, 32'h50, '0);                   // backward jump
    send_word(MODE_ADD, 32'h102, 64'hDEAD_BEEF_CAFE_F00D);
    send_word(MODE_ADVANCE, 32'h103, '0);                  // strands 0x102 in its slot
    send_word(MODE_ADD, 32'h142, '1);                      // same slot, stale owner
    send_word(MODE_ADVANCE, 32'h13F, '0);
    send_word(MODE_GET, '0, '0);
    send_word(MODE_ADVANCE, 32'hFFFF_FFC1, '0);
    send_word(MODE_ADD, 32'hFFFF_FFFF, 64'h8000_0000_0000_0001); // in window only at 33 bits
    send_word(MODE_ADVANCE, 32'hFFFF_FFFF, '0);
    send_word(MODE_GET, '0, '0);                           // pop at the top, head wraps to 0
    send_word(MODE_GET, '0, '0);                           // unstarted again
    send_word(MODE_START, 32'h2, '0);
    send_word(MODE_ADD, 32'h2, '1);                        // stale tag above the new seq
    send_word(MODE_ADVANCE, 32'h102, '0);
    send_word(MODE_GET, '0, '0);                           // pop the stranded word
  endtask

  // Receiver holds off long enough for the block to fill and stall its
  // input while the sender keeps offering words.
  task automatic test_receiver_holdoff();
    hold_request   = 300;
    sender_gapless = 1;
    if (head_seq == '0) send_word(MODE_START, 32'h1000, rand_payload());
    add_shuffled(head_seq, 40);
    pop_ready();
    flush_window();
    sender_gapless = 0;
    wait_drained();
  endtask

  task automatic test_random_sessions();
    while (words_sent < ITEM_TARGET) begin
      if ($urandom_range(0, 11) == 0) wait_drained();
      sender_gapless = ($urandom_range(0, 7) == 0);
      run_session();
    end
  endtask

  // Receiver: a 16-bit ready pattern, redrawn at random after each pass, overridden by hold-offs.
  always @(posedge clk) begin
    if (hold_request > 0) begin
      hold_left    = hold_request;
      hold_request = 0;
    end
    if (hold_left > 0) begin
      out_ready <= 1'b0;
      hold_left = hold_left - 1;
    end else begin
      out_ready <= ready_pattern[pattern_pos];
      if (pattern_pos == 15) begin
        pattern_pos = 0;
        case ($urandom_range(0, 3))
          0: ready_pattern = 16'hFFFF;
          1: ready_pattern = 16'($urandom);
          2: ready_pattern = 16'($urandom | $urandom);
          default: ready_pattern = 16'($urandom & $urandom) | 16'h0001;
        endcase
      end else begin
        pattern_pos++;
      end
    end
  end

  // Result checker: each accepted word against the oldest owed result.
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (expected_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("%0t: result word %h arrived with nothing owed", $time, out_data);
        end
      end else begin
        want = expected_results.pop_front();
        results_checked++;
        if (want.status <= ST_BACKWARD) status_hits[want.status]++;
        if (out_data.status !== want.status || out_data.seq_out !== want.seq_out ||
            out_data.data_out !== want.data_out ||
            out_data.next_ready !== want.next_ready) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("%0t: result %0d wrong (expected / actual)", $time, results_checked);
            $display("  status %0d / %0d  seq_out %h / %h  next_ready %b / %b",
                     want.status, out_data.status, want.seq_out, out_data.seq_out,
                     want.next_ready, out_data.next_ready);
            $display("  data_out %h / %h", want.data_out, out_data.data_out);
          end
        end
      end
    end
  end

  // Run limit, several times the slowest legal run.
  initial begin
    #8_000_000;
    $display("timeout with %0d results still owed", expected_results.size());
    $display("sequence_reorder_buffer test failed");
    $finish;
  end

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_edge_cases();
    wait_drained();
    test_receiver_holdoff();
    test_random_sessions();
    wait_drained();
    // idle a while so a stray extra result would still be caught
    repeat (20) @(posedge clk);

    $display("Run covered %0d words, %0d checked results, %0d head wraps, %0d mismatches.",
             words_sent, results_checked, seq_wraps, mismatches);
    $write("Status mix: ok %0d, unstarted %0d, invalid %0d, full %0d, exists %0d,",
           status_hits[ST_OK], status_hits[ST_NOT_STARTED], status_hits[ST_INVALID],
           status_hits[ST_FULL], status_hits[ST_EXISTS]);
    $display(" busy %0d, not ready %0d, started %0d, backward %0d.",
             status_hits[ST_BUSY], status_hits[ST_NOT_READY], status_hits[ST_STARTED],
             status_hits[ST_BACKWARD]);
    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("sequence_reorder_buffer test passed");
    end else begin
      $display("%0d results never arrived", expected_results.size());
      $display("sequence_reorder_buffer test failed");
    end
    $finish;
  end

endmodule
